// File: rtl/sof_pkg.sv
package sof_pkg;

  localparam int SWEEP_STEPS = 181;
  localparam int DIST_BITS   = 13;
  localparam int ANGLE_W     = $clog2(SWEEP_STEPS);
  localparam int TAB_N       = 1 << ANGLE_W;
  localparam int MAG_W       = 31;
  localparam int PROD_W      = DIST_BITS + MAG_W;

  localparam int THR_W       = 13;
  localparam int WID_W       = 14;
  localparam int DEG_W       = 8;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SMALL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 2'd3;

  localparam logic [THR_W-1:0] RST_NEAR_THR   = 13'd1600;
  localparam logic [WID_W-1:0] RST_MIN_WIDTH  = 14'd160;
  localparam logic [WID_W-1:0] RST_INIT_SMALL = 14'd16000;
  localparam logic [DEG_W-1:0] RST_CENTER     = 8'd90;

  localparam logic KIND_OBJECT  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic [THR_W-1:0] near_thr;
    logic [WID_W-1:0] min_width;
    logic [WID_W-1:0] init_small;
    logic [DEG_W-1:0] center;
  } cfg_t;

  typedef struct packed {
    logic                 close;
    logic                 done;
    logic [DIST_BITS-1:0] med;
    logic [MAG_W-1:0]     mag;
    logic                 neg;
    logic [ANGLE_W-1:0]   r;
    logic [ANGLE_W-1:0]   mid;
  } op_t;

  typedef struct packed {
    logic              kind;
    logic [DEG_W-1:0]  angular_width;
    logic [DEG_W-1:0]  mid_angle;
    logic [WID_W-1:0]  linear_width;
    logic [WID_W-1:0]  smallest_width;
    logic [DEG_W-1:0]  smallest_mid;
    logic signed [DEG_W-1:0] turn_amount;
    logic              last_flag;
  } res_t;

  typedef logic [MAG_W:0] sine_tab_t [TAB_N];

  // {negative, Q30 magnitude} of sin(r * 3.14 / 180), Taylor series to x^13
  function automatic logic [MAG_W:0] sine_entry(input int unsigned r);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic        neg;
    int          k;
    x   = ((64'(r) * 64'd314) << 30) / 64'd18000;
    neg = 1'b0;
    if (x > PI_Q30) begin
      x   = x - PI_Q30;
      neg = 1'b1;
      if (x > PI_Q30) x = PI_Q30;
    end
    if (x > (PI_Q30 >> 1)) x = PI_Q30 - x;
    sum  = x;
    term = x;
    for (k = 1; k <= 6; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if ((k % 2) == 1) sum = (sum > term) ? sum - term : 64'd0;
      else sum = sum + term;
    end
    if (sum > ONE_Q30) sum = ONE_Q30;
    if (sum == 64'd0) neg = 1'b0;
    return {neg, sum[MAG_W-1:0]};
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i < TAB_N; i++) tab[i] = sine_entry(i);
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// File: rtl/sof_front.sv
module sof_front import sof_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [DIST_BITS-1:0] in_distance,
  output logic                 in_full,
  input  logic [THR_W-1:0]     near_thr,
  output logic                 op_push,
  output op_t                  op_word,
  input  logic                 op_full
);

  logic [ANGLE_W-1:0]   angle_r, angle_nxt;
  logic [1:0]           slot_r, slot_nxt;
  logic                 in_obj_r, in_obj_nxt;
  logic [ANGLE_W-1:0]   start_r, start_nxt;
  logic [DIST_BITS-1:0] win0_r, win1_r;

  logic                 accept, last_angle, grp_end, opens, closes;
  logic [DIST_BITS-1:0] lo, hi, med;
  logic [ANGLE_W-1:0]   tag, r, mid;
  logic [MAG_W:0]       sine;

  assign accept     = in_push && !op_full;
  assign in_full    = op_full;
  assign last_angle = angle_r == ANGLE_W'(SWEEP_STEPS - 1);
  assign grp_end    = slot_r == 2'd2;

  // three-way median of the group, third sample straight from the port
  always_comb begin
    lo  = (win0_r < win1_r) ? win0_r : win1_r;
    hi  = (win0_r < win1_r) ? win1_r : win0_r;
    med = (in_distance < lo) ? lo : ((in_distance > hi) ? hi : in_distance);
  end

  assign tag    = angle_r - 1'b1;
  assign r      = tag - start_r;
  assign mid    = tag - (r >> 1);
  assign sine   = SINE_TAB[r];
  assign opens  = grp_end && (THR_W'(med) < near_thr) && !in_obj_r;
  assign closes = grp_end && (THR_W'(med) >= near_thr) && in_obj_r;

  assign op_push = accept && (closes || last_angle);
  always_comb begin
    op_word.close = closes;
    op_word.done  = last_angle;
    op_word.med   = med;
    op_word.mag   = sine[MAG_W-1:0];
    op_word.neg   = sine[MAG_W];
    op_word.r     = r;
    op_word.mid   = mid;
  end

  always_comb begin
    angle_nxt  = angle_r;
    slot_nxt   = slot_r;
    in_obj_nxt = in_obj_r;
    start_nxt  = start_r;
    if (accept) begin
      if (last_angle) begin
        angle_nxt  = '0;
        slot_nxt   = 2'd0;
        in_obj_nxt = 1'b0;
        start_nxt  = '0;
      end else begin
        angle_nxt = angle_r + 1'b1;
        slot_nxt  = grp_end ? 2'd0 : slot_r + 2'd1;
        if (opens) begin
          in_obj_nxt = 1'b1;
          start_nxt  = tag;
        end else if (closes) begin
          in_obj_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r  <= '0;
      slot_r   <= 2'd0;
      in_obj_r <= 1'b0;
      start_r  <= '0;
    end else begin
      angle_r  <= angle_nxt;
      slot_r   <= slot_nxt;
      in_obj_r <= in_obj_nxt;
      start_r  <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && slot_r == 2'd0) win0_r <= in_distance;
    if (accept && slot_r == 2'd1) win1_r <= in_distance;
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n) slot_r != 2'd3)
    else $error("group slot out of range");
  a_open_before: assert property (@(posedge clk) disable iff (!rst_n)
    in_obj_r |-> start_r < angle_r)
    else $error("open object starts at or after current angle");

endmodule

// File: rtl/sof_opq.sv
module sof_opq import sof_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  din,
  output logic full,
  input  logic pop,
  output op_t  dout,
  output logic empty
);

  op_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic               do_push, do_pop;

  assign full    = count_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_PTR_W+1)'(Q_DEPTH))
    else $error("op queue overfilled");

endmodule

// File: rtl/sof_back.sv
module sof_back import sof_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic op_empty,
  output logic op_pop,
  input  op_t  op_word,
  output logic res_push,
  output res_t res_word,
  input  logic res_full
);

  logic                 s1_v_r;
  op_t                  s1_op_r;
  logic [DIST_BITS-1:0] s1_hi_r;
  logic                 s1_frac_r;
  logic [WID_W-1:0]     best_w_r, best_w_nxt;
  logic [DEG_W-1:0]     best_mid_r, best_mid_nxt;

  logic                 s1_ready, fire, qual, above_min;
  logic [PROD_W-1:0]    prod;
  logic [WID_W-1:0]     w_hi, lin, best_w_upd;
  logic [DEG_W-1:0]     best_mid_upd;
  logic signed [DEG_W:0] diff, turn9;

  assign s1_ready = !s1_v_r || !res_full;
  assign op_pop   = !op_empty && s1_ready;
  assign prod     = PROD_W'(op_word.med) * PROD_W'(op_word.mag);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (s1_ready) s1_v_r <= op_pop;
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      s1_op_r   <= op_word;
      s1_hi_r   <= prod[MAG_W+DIST_BITS-2:MAG_W-1];
      s1_frac_r <= |prod[MAG_W-2:0];
    end
  end

  // integer part of the Q30 product plus a sticky fraction bit covers the compares
  assign fire      = s1_v_r && !res_full;
  assign res_push  = fire;
  assign w_hi      = WID_W'(s1_hi_r);
  assign lin       = s1_op_r.neg ? '0 : w_hi;
  assign above_min = (w_hi > cfg.min_width) || ((w_hi == cfg.min_width) && s1_frac_r);
  assign qual      = s1_op_r.close && !s1_op_r.neg && above_min && (w_hi < best_w_r);
  assign best_w_upd   = qual ? {w_hi[WID_W-1:4], 4'b0000} : best_w_r;
  assign best_mid_upd = qual ? DEG_W'(s1_op_r.mid) : best_mid_r;

  // halve toward zero
  assign diff  = $signed({1'b0, best_mid_upd}) - $signed({1'b0, cfg.center});
  assign turn9 = (diff + $signed({{DEG_W{1'b0}}, diff[DEG_W]})) >>> 1;

  always_comb begin
    res_word           = '0;
    res_word.last_flag = 1'b1;
    if (s1_op_r.done) begin
      res_word.kind           = KIND_SUMMARY;
      res_word.smallest_width = best_w_upd;
      res_word.smallest_mid   = best_mid_upd;
      res_word.turn_amount    = turn9[DEG_W-1:0];
    end else begin
      res_word.kind          = KIND_OBJECT;
      res_word.angular_width = DEG_W'(s1_op_r.r);
      res_word.mid_angle     = DEG_W'(s1_op_r.mid);
      res_word.linear_width  = lin;
    end
  end

  always_comb begin
    best_w_nxt   = best_w_r;
    best_mid_nxt = best_mid_r;
    if (fire) begin
      if (s1_op_r.done) begin
        best_w_nxt   = cfg.init_small;
        best_mid_nxt = cfg.center;
      end else begin
        best_w_nxt   = best_w_upd;
        best_mid_nxt = best_mid_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_w_r   <= RST_INIT_SMALL;
      best_mid_r <= RST_CENTER;
    end else begin
      best_w_r   <= best_w_nxt;
      best_mid_r <= best_mid_nxt;
    end
  end

  a_sweep_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_op_r.done) |=> best_w_r == $past(cfg.init_small))
    else $error("smallest width not reloaded at sweep end");

endmodule

// File: rtl/sof_outq.sv
module sof_outq import sof_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  output logic full,
  input  logic pop,
  output res_t dout,
  output logic empty
);

  res_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic               do_push, do_pop;

  assign full    = count_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_PTR_W+1)'(Q_DEPTH))
    else $error("result queue overfilled");

endmodule

// File: rtl/sweep_object_finder_unit.sv
// Path: the front classifies each accepted word and pushes an op into the 4-entry op queue
// when an object closes or the sweep ends; the back end registers the multiply stage, then
// writes the 4-entry result queue read by out_. One word per cycle while in_full is low.
// Reset (rst_n low at a clock edge): queues empty, sweep restarts at angle 0,
// registers back to 1600 / 160 / 16000 / 90.
module sweep_object_finder_unit import sof_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  logic [DIST_BITS-1:0]    in_distance,
  output logic                    in_full,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic                    out_kind,
  output logic [DEG_W-1:0]        out_angular_width,
  output logic [DEG_W-1:0]        out_mid_angle,
  output logic [WID_W-1:0]        out_linear_width,
  output logic [WID_W-1:0]        out_smallest_width,
  output logic [DEG_W-1:0]        out_smallest_mid,
  output logic signed [DEG_W-1:0] out_turn_amount,
  output logic                    out_last_flag,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cfg_t cfg_r;
  op_t  fe_word, be_word;
  logic fe_push, opq_full, opq_empty, be_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_thr   <= RST_NEAR_THR;
      cfg_r.min_width  <= RST_MIN_WIDTH;
      cfg_r.init_small <= RST_INIT_SMALL;
      cfg_r.center     <= RST_CENTER;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEAR_THR:   cfg_r.near_thr   <= cfg_data[THR_W-1:0];
        REG_MIN_WIDTH:  cfg_r.min_width  <= cfg_data[WID_W-1:0];
        REG_INIT_SMALL: cfg_r.init_small <= cfg_data[WID_W-1:0];
        REG_CENTER:     cfg_r.center     <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  sof_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_distance (in_distance),
    .in_full     (in_full),
    .near_thr    (cfg_r.near_thr),
    .op_push     (fe_push),
    .op_word     (fe_word),
    .op_full     (opq_full)
  );

  sof_opq u_opq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .din   (fe_word),
    .full  (opq_full),
    .pop   (be_pop),
    .dout  (be_word),
    .empty (opq_empty)
  );

  sof_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .op_empty (opq_empty),
    .op_pop   (be_pop),
    .op_word  (be_word),
    .res_push (res_push),
    .res_word (res_in),
    .res_full (res_full)
  );

  sof_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign out_kind           = res_out.kind;
  assign out_angular_width  = res_out.angular_width;
  assign out_mid_angle      = res_out.mid_angle;
  assign out_linear_width   = res_out.linear_width;
  assign out_smallest_width = res_out.smallest_width;
  assign out_smallest_mid   = res_out.smallest_mid;
  assign out_turn_amount    = res_out.turn_amount;
  assign out_last_flag      = res_out.last_flag;

endmodule
